### sv/kt_pkg.sv
// ----------------------------------------------------------------------------
// kt_pkg
// Shared types and constants for the Kendall tau rank correlation block.
// ----------------------------------------------------------------------------
`default_nettype none

package kt_pkg;

  localparam int RANK_W      = 10;
  localparam int IN_TDATA_W  = 16;

  localparam int CONC_W      = 19;
  localparam int DISC_W      = 19;
  localparam int TAU_W       = 16;
  localparam int TOTAL_W     = 11;
  localparam int OUT_FIELD_W = CONC_W + DISC_W + TAU_W + TOTAL_W;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
  localparam int OUT_TUSER_W = 2;
  localparam int WIDE_W      = 64;

  localparam int TUSER_UNDEF = 0;
  localparam int TUSER_OVF   = 1;

  localparam int Q_W         = 15;
  localparam int Q_STEP_W    = 4;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              placed;
    logic [RANK_W-1:0] rank;
  } tok_t;

endpackage

`default_nettype wire

### sv/kt_cell.sv
// ----------------------------------------------------------------------------
// kt_cell
// One chain cell: holds one rank, compares it with the passing item and
// forwards the item with its running concordant count to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module kt_cell #(
  parameter int MAX_ITEMS = 1024,
  localparam int CNT_W = $clog2(MAX_ITEMS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire kt_pkg::tok_t  tok_i,
  input  wire logic [CNT_W-1:0] nc_i,
  output kt_pkg::tok_t       tok_o,
  output logic [CNT_W-1:0]   nc_o
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [kt_pkg::RANK_W-1:0] rank_r;
  kt_pkg::tok_t              tok_r;
  kt_pkg::tok_t              tok_nxt;
  logic [CNT_W-1:0]          nc_r;
  logic [CNT_W-1:0]          nc_nxt;
  logic                      hit;
  logic                      take;

  always_comb begin
    hit       = tok_i.valid && !tok_i.placed && valid_r;
    take      = tok_i.valid && !tok_i.placed && !valid_r;
    nc_nxt    = nc_i + CNT_W'(hit && (rank_r < tok_i.rank));
    tok_nxt   = tok_i;
    tok_nxt.placed = tok_i.placed | take;
    valid_nxt = valid_r;
    if (tok_i.valid && tok_i.last) begin
      valid_nxt = 1'b0;
    end else if (take) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_r.valid <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nc_r <= nc_nxt;
      if (take && !tok_i.last) begin
        rank_r <= tok_i.rank;
      end
    end
  end

  assign tok_o = tok_r;
  assign nc_o  = nc_r;

endmodule

`default_nettype wire

### sv/kt_tally.sv
// ----------------------------------------------------------------------------
// kt_tally
// Chain end: sums pair counts per ranking, then forms tau with a
// one-bit-per-cycle divider and holds the result until transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module kt_tally #(
  parameter int MAX_ITEMS = 1024,
  localparam int CNT_W  = $clog2(MAX_ITEMS),
  localparam int N_W    = $clog2(MAX_ITEMS + 1),
  localparam int PAIR_W = $clog2(longint'(MAX_ITEMS) * (MAX_ITEMS - 1) / 2 + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire kt_pkg::tok_t                      tok_i,
  input  wire logic [CNT_W-1:0]                  nc_i,
  output logic                                   en,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [kt_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [kt_pkg::OUT_TUSER_W-1:0]         out_tuser
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  state_t                     state_r;
  logic [PAIR_W-1:0]          acc_nc_r;
  logic [PAIR_W-1:0]          acc_nd_r;
  logic [N_W-1:0]             n_r;
  logic                       ovf_r;

  logic [PAIR_W-1:0]          acc_nc_nxt;
  logic [PAIR_W-1:0]          acc_nd_nxt;
  logic [N_W-1:0]             n_nxt;
  logic                       ovf_nxt;
  logic                       take;

  logic [PAIR_W-1:0]          fin_nc_r;
  logic [PAIR_W-1:0]          fin_nd_r;
  logic [N_W-1:0]             fin_n_r;
  logic                       fin_ovf_r;
  logic                       und_r;
  logic                       neg_r;
  logic [PAIR_W-1:0]          pairs_r;
  logic [PAIR_W:0]            rem_r;
  logic [kt_pkg::Q_W-1:0]     q_r;
  logic [kt_pkg::Q_STEP_W-1:0] step_r;

  logic [2*N_W-1:0]           prod;
  logic                       ge;
  logic [PAIR_W:0]            rem_sub;
  logic [kt_pkg::TAU_W-1:0]   tau_mag;
  logic [kt_pkg::TAU_W-1:0]   tau;
  logic [kt_pkg::WIDE_W-1:0]  nc_wide;
  logic [kt_pkg::WIDE_W-1:0]  nd_wide;
  logic [kt_pkg::WIDE_W-1:0]  n_wide;

  always_comb begin
    en         = !(tok_i.valid && tok_i.last && (state_r != S_IDLE));
    take       = en && tok_i.valid;
    acc_nc_nxt = acc_nc_r;
    acc_nd_nxt = acc_nd_r;
    n_nxt      = n_r;
    ovf_nxt    = ovf_r | !tok_i.placed;
    if (tok_i.placed) begin
      acc_nc_nxt = acc_nc_r + PAIR_W'(nc_i);
      acc_nd_nxt = acc_nd_r + (PAIR_W'(n_r) - PAIR_W'(nc_i));
      n_nxt      = n_r + N_W'(1);
    end
  end

  always_comb begin
    prod    = (2*N_W)'(fin_n_r) * (2*N_W)'(fin_n_r - N_W'(1));
    ge      = rem_r >= (PAIR_W+1)'(pairs_r);
    rem_sub = ge ? (rem_r - (PAIR_W+1)'(pairs_r)) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      acc_nc_r <= '0;
      acc_nd_r <= '0;
      n_r      <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (take) begin
        if (tok_i.last) begin
          acc_nc_r  <= '0;
          acc_nd_r  <= '0;
          n_r       <= '0;
          ovf_r     <= 1'b0;
          fin_nc_r  <= acc_nc_nxt;
          fin_nd_r  <= acc_nd_nxt;
          fin_n_r   <= n_nxt;
          fin_ovf_r <= ovf_nxt;
          state_r   <= S_MUL;
        end else begin
          acc_nc_r <= acc_nc_nxt;
          acc_nd_r <= acc_nd_nxt;
          n_r      <= n_nxt;
          ovf_r    <= ovf_nxt;
        end
      end
      case (state_r)
        S_MUL: begin
          pairs_r <= PAIR_W'(prod >> 1);
          neg_r   <= fin_nd_r > fin_nc_r;
          rem_r   <= (fin_nd_r > fin_nc_r) ? (PAIR_W+1)'(fin_nd_r - fin_nc_r)
                                           : (PAIR_W+1)'(fin_nc_r - fin_nd_r);
          und_r   <= fin_n_r < N_W'(2);
          q_r     <= '0;
          step_r  <= '0;
          state_r <= (fin_n_r < N_W'(2)) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          q_r    <= {q_r[kt_pkg::Q_W-2:0], ge};
          rem_r  <= rem_sub << 1;
          step_r <= step_r + kt_pkg::Q_STEP_W'(1);
          if (step_r == kt_pkg::Q_STEP_W'(kt_pkg::Q_W - 1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    tau_mag    = {1'b0, q_r};
    tau        = neg_r ? (~tau_mag + kt_pkg::TAU_W'(1)) : tau_mag;
    nc_wide    = kt_pkg::WIDE_W'(fin_nc_r);
    nd_wide    = kt_pkg::WIDE_W'(fin_nd_r);
    n_wide     = kt_pkg::WIDE_W'(fin_n_r);
    out_tvalid = state_r == S_OUT;
    out_tdata  = {{kt_pkg::OUT_PAD_W{1'b0}},
                  n_wide[kt_pkg::TOTAL_W-1:0],
                  tau,
                  nd_wide[kt_pkg::DISC_W-1:0],
                  nc_wide[kt_pkg::CONC_W-1:0]};
    out_tuser  = '0;
    out_tuser[kt_pkg::TUSER_UNDEF] = und_r;
    out_tuser[kt_pkg::TUSER_OVF]   = fin_ovf_r;
  end

endmodule

`default_nettype wire

### sv/kendall_tau_rank_correlation.sv
// ----------------------------------------------------------------------------
// kendall_tau_rank_correlation
// Streams one ranking through a chain of rank cells and reports pair counts
// and Kendall tau in Q2.14 on the last item of each ranking.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; a last item that reaches the chain end while
//   the previous result is still being formed or waits to transfer holds the chain.
// Result path: after the last item transfers it passes the MAX_ITEMS chain stages
//   (the first on the transfer edge), a capture into the tally, a multiply step
//   and the divide before out_tvalid rises; below two items the divide is skipped.
// Reset clears cell valid bits, chain slots and counters; stored ranks hold.
`default_nettype none

module kendall_tau_rank_correlation #(
  parameter int MAX_ITEMS = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [kt_pkg::IN_TDATA_W-1:0]    in_tdata,   // [9:0] exp_rank
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [18:0] concordant, [37:19] discordant, [53:38] tau_q14, [64:54] item_total
  output logic [kt_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic [kt_pkg::OUT_TUSER_W-1:0]        out_tuser   // [0] tau_undefined, [1] overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS);

  kt_pkg::tok_t     tok [0:MAX_ITEMS];
  logic [CNT_W-1:0] nc  [0:MAX_ITEMS];
  logic             en;

  assign in_tready = en;

  always_comb begin
    tok[0].valid  = in_tvalid;
    tok[0].last   = in_tlast;
    tok[0].placed = 1'b0;
    tok[0].rank   = in_tdata[kt_pkg::RANK_W-1:0];
    nc[0]         = '0;
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    kt_cell #(
      .MAX_ITEMS (MAX_ITEMS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (tok[i]),
      .nc_i  (nc[i]),
      .tok_o (tok[i+1]),
      .nc_o  (nc[i+1])
    );
  end

  kt_tally #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_tally (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_i      (tok[MAX_ITEMS]),
    .nc_i       (nc[MAX_ITEMS]),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### sv/kt_checker.sv
// ----------------------------------------------------------------------------
// kt_checker
// Port-level checks on the result stream of the Kendall tau block.
// ----------------------------------------------------------------------------
`default_nettype none

module kt_checker #(
  parameter int MAX_ITEMS = 1024
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [kt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [kt_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam bit EXACT = MAX_ITEMS <= 1024;

  logic [31:0] conc;
  logic [31:0] disc;
  logic [31:0] total;
  logic [31:0] pairs;
  logic [15:0] tau;
  logic        undef;

  always_comb begin
    conc    = 32'(out_tdata[18:0]);
    disc    = 32'(out_tdata[37:19]);
    tau     = out_tdata[53:38];
    total   = 32'(out_tdata[64:54]);
    pairs   = (total * (total - 32'd1)) >> 1;
    undef   = out_tuser[kt_pkg::TUSER_UNDEF];
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_undef_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && undef |-> tau == '0 && conc == '0 && disc == '0)
    else $error("undefined tau with nonzero counts");

  a_pair_sum: assert property (@(posedge clk) disable iff (!rst_n)
    EXACT && out_tvalid && !undef |-> conc + disc == pairs && total >= 32'd2)
    else $error("pair counts do not match item total");

  a_tau_sign: assert property (@(posedge clk) disable iff (!rst_n)
    EXACT && out_tvalid && !undef |->
      ((conc >= disc) ? !tau[15] : (tau[15] || (tau == '0))))
    else $error("tau sign disagrees with counts");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

bind kendall_tau_rank_correlation kt_checker #(
  .MAX_ITEMS (MAX_ITEMS)
) u_kt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
